@@ rtl/core/bmhq_pkg.sv @@
// Shared types and constants for the binary max-heap priority queue.
// Depends on nothing; used by bmhq_level_cell and binary_max_heap_queue.
package bmhq_pkg;

  // Default and largest supported configuration.
  localparam int HEAP_DEPTH_DEF = 1024;
  localparam int KEY_WIDTH_DEF  = 32;
  localparam int DEPTH_MAX      = 65536;

  // A level number fits this many bits for every supported depth.
  localparam int LVL_BITS = $clog2($clog2(DEPTH_MAX + 1));

  // Fixed widths of the item fields.
  localparam int IN_KEY_W    = 32;
  localparam int OUT_KEY_W   = 32;
  localparam int OUT_COUNT_W = 11;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    req_type_t             req_type;
    logic [IN_KEY_W-1:0]   key_in;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [OUT_KEY_W-1:0]   removed_key;
    logic [OUT_KEY_W-1:0]   top_key;
    logic [OUT_COUNT_W-1:0] held_count;
    logic                   is_empty;
  } rsp_t;

  // Operation carried by the token that walks down the level cells.
  typedef enum logic {
    TOK_INSERT = 1'b0,
    TOK_SIFT   = 1'b1
  } tok_op_t;

  typedef struct packed {
    logic                valid;
    tok_op_t             op;
    logic [LVL_BITS-1:0] last_lvl;
  } tok_ctrl_t;

endpackage

@@ rtl/core/bmhq_level_cell.sv @@
// One level of the heap: the keys of that level in two row memories
// (even and odd slots) and the compare step for a passing token.
// Depends on bmhq_pkg.
module bmhq_level_cell #(
  parameter int LEVEL     = 0,
  parameter int KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF,
  parameter int CNT_W     = $clog2(bmhq_pkg::HEAP_DEPTH_DEF + 1),
  parameter int POS_W     = $clog2(bmhq_pkg::HEAP_DEPTH_DEF + 1) - 1
) (
  input  logic                 clk,
  input  logic                 rst,
  // Token from the level above.
  input  bmhq_pkg::tok_ctrl_t  tok_in,
  input  logic [KEY_WIDTH-1:0] tok_key_in,
  input  logic [POS_W-1:0]     tok_pos_in,
  input  logic [POS_W-1:0]     tok_path_in,
  // Token to the level below.
  output bmhq_pkg::tok_ctrl_t  tok_out,
  output logic [KEY_WIDTH-1:0] tok_key_out,
  output logic [POS_W-1:0]     tok_pos_out,
  output logic [POS_W-1:0]     tok_path_out,
  // Write-back from the level below into this level.
  input  logic                 wb_in_valid,
  input  logic [POS_W-1:0]     wb_in_pos,
  input  logic [KEY_WIDTH-1:0] wb_in_key,
  // Write-back from this level into the level above.
  output logic                 wb_out_valid,
  output logic [POS_W-1:0]     wb_out_pos,
  output logic [KEY_WIDTH-1:0] wb_out_key,
  // Direct read of one slot while no token is in flight.
  input  logic [POS_W-1:0]     fetch_pos,
  output logic [KEY_WIDTH-1:0] fetch_key,
  // Number of keys held, already updated for the current request.
  input  logic [CNT_W-1:0]     count
);

  localparam int ROW_W = (LEVEL < 2) ? 1 : LEVEL - 1;
  localparam int ROWS  = 1 << ROW_W;
  localparam int LB    = bmhq_pkg::LVL_BITS;

  logic [KEY_WIDTH-1:0] mem_lo [ROWS];
  logic [KEY_WIDTH-1:0] mem_hi [ROWS];

  logic [ROW_W-1:0]     raddr;
  logic [KEY_WIDTH-1:0] rd_lo;
  logic [KEY_WIDTH-1:0] rd_hi;
  logic                 fetch_half;

  bmhq_pkg::tok_ctrl_t  tok_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [POS_W-1:0]     pos_q;
  logic [POS_W-1:0]     path_q;

  logic [KEY_WIDTH-1:0] node;
  logic [CNT_W-1:0]     left_n;
  logic                 left_ok;
  logic                 right_ok;
  logic                 pick_r;
  logic [KEY_WIDTH-1:0] big;

  logic                 own_we;
  logic                 own_half;
  logic [ROW_W-1:0]     own_row;
  logic [KEY_WIDTH-1:0] own_key;

  bmhq_pkg::tok_ctrl_t  tok_next;
  logic [KEY_WIDTH-1:0] tok_key_next;
  logic [POS_W-1:0]     tok_pos_next;
  logic [POS_W-1:0]     tok_path_next;
  logic                 wb_valid_next;

  logic                 we;
  logic                 whalf;
  logic [ROW_W-1:0]     wrow;
  logic [KEY_WIDTH-1:0] wkey;

  // A sift token addresses the pair of children of its parent slot; an
  // insert token addresses the row of its own slot.
  always_comb begin
    if (tok_in.valid) begin
      if (tok_in.op == bmhq_pkg::TOK_SIFT) begin
        raddr = ROW_W'(tok_pos_in);
      end else begin
        raddr = ROW_W'(tok_pos_in >> 1);
      end
    end else begin
      raddr = ROW_W'(fetch_pos >> 1);
    end
  end

  always_ff @(posedge clk) begin
    rd_lo      <= mem_lo[raddr];
    rd_hi      <= mem_hi[raddr];
    fetch_half <= fetch_pos[0];
  end

  assign fetch_key = fetch_half ? rd_hi : rd_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q.valid <= 1'b0;
    end else begin
      tok_q.valid <= tok_in.valid;
    end
    tok_q.op       <= tok_in.op;
    tok_q.last_lvl <= tok_in.last_lvl;
    key_q          <= tok_key_in;
    pos_q          <= tok_pos_in;
    path_q         <= tok_path_in;
  end

  // Children of the parent slot; the root level has a single slot.
  always_comb begin
    node     = pos_q[0] ? rd_hi : rd_lo;
    left_n   = (CNT_W'(1) << LEVEL) | (CNT_W'(pos_q) << 1);
    left_ok  = (left_n <= count);
    right_ok = (LEVEL != 0) && (left_n < count);
    pick_r   = right_ok && (rd_lo < rd_hi);
    big      = pick_r ? rd_hi : rd_lo;
  end

  always_comb begin
    own_we         = 1'b0;
    own_half       = 1'b0;
    own_row        = '0;
    own_key        = key_q;
    tok_next       = tok_q;
    tok_next.valid = 1'b0;
    tok_key_next   = key_q;
    tok_pos_next   = '0;
    tok_path_next  = '0;
    wb_valid_next  = 1'b0;
    if (tok_q.valid) begin
      case (tok_q.op)
        bmhq_pkg::TOK_INSERT: begin
          own_row  = ROW_W'(pos_q >> 1);
          own_half = pos_q[0];
          if (tok_q.last_lvl == LB'(LEVEL)) begin
            // The new slot: the carried key lands here.
            own_we = 1'b1;
          end else begin
            tok_next.valid = 1'b1;
            tok_pos_next   = (pos_q << 1) | POS_W'(path_q[POS_W-1]);
            tok_path_next  = path_q << 1;
            if (key_q > node) begin
              own_we       = 1'b1;
              tok_key_next = node;
            end
          end
        end
        bmhq_pkg::TOK_SIFT: begin
          own_row  = ROW_W'(pos_q);
          own_half = pick_r;
          if (left_ok && (key_q < big)) begin
            // Swap: the larger child moves up, the key moves down.
            own_we         = 1'b1;
            wb_valid_next  = 1'b1;
            tok_next.valid = 1'b1;
            tok_pos_next   = (pos_q << 1) | POS_W'(pick_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (own_we) begin
      we    = 1'b1;
      whalf = own_half;
      wrow  = own_row;
      wkey  = own_key;
    end else begin
      we    = wb_in_valid;
      whalf = wb_in_pos[0];
      wrow  = ROW_W'(wb_in_pos >> 1);
      wkey  = wb_in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (we && !whalf) begin
      mem_lo[wrow] <= wkey;
    end
    if (we && whalf) begin
      mem_hi[wrow] <= wkey;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      wb_out_valid  <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
      wb_out_valid  <= wb_valid_next;
    end
    tok_out.op       <= tok_next.op;
    tok_out.last_lvl <= tok_next.last_lvl;
    tok_key_out      <= tok_key_next;
    tok_pos_out      <= tok_pos_next;
    tok_path_out     <= tok_path_next;
    wb_out_pos       <= pos_q;
    wb_out_key       <= big;
  end

endmodule

@@ rtl/core/binary_max_heap_queue.sv @@
// Binary max-heap priority queue: top level with request sequencer and the
// row of level cells. Depends on bmhq_pkg and bmhq_level_cell.
//
// The queue holds up to HEAP_DEPTH unsigned keys of KEY_WIDTH bits as a
// complete binary max-heap, one level of the tree in each cell of a chain of
// $clog2(HEAP_DEPTH+1) cells (11 at the default depth). Every request item
// gives exactly one result item with a status, the removed maximum, the new
// top key and the count. One request is in service at a time. A token
// walks the cells from the root, each cell registering the memory read
// and then the compare. The sequencer waits until the last write-back has
// landed, then reads the root back for the top key and loads the output
// register. A remove that leaves keys behind first reads the last key out
// of its level before the sift token starts at the root. Inserts on a full
// heap and removes on an empty heap are flagged and change nothing; they,
// and a remove of the only key, skip the token walk. The result waits in
// an output register, so the next request is taken in the cycle after the
// current one has been handed to it.
module binary_max_heap_queue #(
  parameter int HEAP_DEPTH = bmhq_pkg::HEAP_DEPTH_DEF,
  parameter int KEY_WIDTH  = bmhq_pkg::KEY_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bmhq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bmhq_pkg::rsp_t rsp
);

  // Tree geometry: NL levels, counts of CW bits, slot positions within a
  // level of PW bits.
  localparam int NL      = $clog2(HEAP_DEPTH + 1);
  localparam int CW      = NL;
  localparam int PW      = NL - 1;
  localparam int LIW     = $clog2(NL);
  localparam int LB      = bmhq_pkg::LVL_BITS;
  localparam int OKW     = bmhq_pkg::OUT_KEY_W;
  localparam int OCW     = bmhq_pkg::OUT_COUNT_W;
  // Cycles for a token to clear the last cell and its write-back to land.
  localparam int RUN_CYC = 2 * NL;
  localparam int WCW     = $clog2(RUN_CYC + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_RUN   = 5'b00100,
    S_TOP   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                  state;
  logic                    phase;
  logic [WCW-1:0]          wait_cnt;
  logic [CW-1:0]           count;
  logic [KEY_WIDTH-1:0]    root_key;
  logic [KEY_WIDTH-1:0]    removed;
  bmhq_pkg::status_t       status;
  logic [LIW-1:0]          fetch_lvl;
  logic [PW-1:0]           fetch_pos;

  // Token entering the root cell.
  bmhq_pkg::tok_ctrl_t     head_tok;
  logic [KEY_WIDTH-1:0]    head_key;
  logic [PW-1:0]           head_pos;
  logic [PW-1:0]           head_path;

  // Chain wiring: entry i feeds cell i, cell i drives entry i+1. Write-backs
  // run the other way: cell i drives wb entry i, cell i reads entry i+1.
  bmhq_pkg::tok_ctrl_t     tok      [NL+1];
  logic [KEY_WIDTH-1:0]    tok_key  [NL+1];
  logic [PW-1:0]           tok_pos  [NL+1];
  logic [PW-1:0]           tok_path [NL+1];
  logic                    wb_valid [NL+1];
  logic [PW-1:0]           wb_pos   [NL+1];
  logic [KEY_WIDTH-1:0]    wb_key   [NL+1];
  logic [KEY_WIDTH-1:0]    fetch_key [NL];

  // Location of the slot that a request works on: the next free slot for
  // an insert, the last held slot for a remove (one-based slot number).
  logic [CW-1:0]           loc_n;
  logic [LIW-1:0]          loc_lvl;
  logic [PW-1:0]           loc_pos;
  logic [PW-1:0]           loc_path;

  always_comb begin
    if (req.req_type == bmhq_pkg::REQ_INSERT) begin
      loc_n = CW'(count + 1'b1);
    end else begin
      loc_n = count;
    end
    loc_lvl = '0;
    for (int i = 0; i < CW; i++) begin
      if (loc_n[i]) begin
        loc_lvl = LIW'(i);
      end
    end
    loc_pos  = PW'(loc_n & ~(CW'(1) << loc_lvl));
    // Branch directions below the root, most significant bit first.
    loc_path = loc_pos << (PW - int'(loc_lvl));
  end

  assign req_stall = (state != S_IDLE);

  assign tok[0]      = head_tok;
  assign tok_key[0]  = head_key;
  assign tok_pos[0]  = head_pos;
  assign tok_path[0] = head_path;
  assign wb_valid[NL] = 1'b0;
  assign wb_pos[NL]   = '0;
  assign wb_key[NL]   = '0;

  for (genvar i = 0; i < NL; i++) begin : g_level
    bmhq_level_cell #(
      .LEVEL    (i),
      .KEY_WIDTH(KEY_WIDTH),
      .CNT_W    (CW),
      .POS_W    (PW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .tok_in      (tok[i]),
      .tok_key_in  (tok_key[i]),
      .tok_pos_in  (tok_pos[i]),
      .tok_path_in (tok_path[i]),
      .tok_out     (tok[i+1]),
      .tok_key_out (tok_key[i+1]),
      .tok_pos_out (tok_pos[i+1]),
      .tok_path_out(tok_path[i+1]),
      .wb_in_valid (wb_valid[i+1]),
      .wb_in_pos   (wb_pos[i+1]),
      .wb_in_key   (wb_key[i+1]),
      .wb_out_valid(wb_valid[i]),
      .wb_out_pos  (wb_pos[i]),
      .wb_out_key  (wb_key[i]),
      .fetch_pos   (fetch_pos),
      .fetch_key   (fetch_key[i]),
      .count       (count)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase          <= 1'b0;
      wait_cnt       <= '0;
      count          <= '0;
      head_tok.valid <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      // A result taken by the receiver clears valid unless a new one is
      // loaded in the same cycle.
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            phase <= 1'b0;
            if (req.req_type == bmhq_pkg::REQ_INSERT) begin
              removed   <= '0;
              fetch_lvl <= '0;
              fetch_pos <= '0;
              if (count == CW'(HEAP_DEPTH)) begin
                status <= bmhq_pkg::STATUS_FULL;
                state  <= S_TOP;
              end else begin
                // Insert walks from the root toward the new slot, pushing
                // the smaller key down at each level.
                status            <= bmhq_pkg::STATUS_OK;
                count             <= CW'(count + 1'b1);
                head_tok.valid    <= 1'b1;
                head_tok.op       <= bmhq_pkg::TOK_INSERT;
                head_tok.last_lvl <= LB'(loc_lvl);
                head_key          <= KEY_WIDTH'(req.key_in);
                head_pos          <= '0;
                head_path         <= loc_path;
                wait_cnt          <= WCW'(RUN_CYC);
                state             <= S_RUN;
              end
            end else begin
              if (count == '0) begin
                removed   <= '0;
                status    <= bmhq_pkg::STATUS_EMPTY;
                fetch_lvl <= '0;
                fetch_pos <= '0;
                state     <= S_TOP;
              end else begin
                status  <= bmhq_pkg::STATUS_OK;
                removed <= root_key;
                count   <= CW'(count - 1'b1);
                if (count == CW'(1)) begin
                  fetch_lvl <= '0;
                  fetch_pos <= '0;
                  state     <= S_TOP;
                end else begin
                  fetch_lvl <= loc_lvl;
                  fetch_pos <= loc_pos;
                  state     <= S_FETCH;
                end
              end
            end
          end
        end
        S_FETCH: begin
          // The last key is read out of its level, then sifted down from
          // the root.
          phase <= !phase;
          if (phase) begin
            head_tok.valid    <= 1'b1;
            head_tok.op       <= bmhq_pkg::TOK_SIFT;
            head_tok.last_lvl <= '0;
            head_key          <= fetch_key[fetch_lvl];
            head_pos          <= '0;
            head_path         <= '0;
            wait_cnt          <= WCW'(RUN_CYC);
            state             <= S_RUN;
          end
        end
        S_RUN: begin
          // The head token is offered to the root cell for one cycle only.
          head_tok.valid <= 1'b0;
          wait_cnt       <= WCW'(wait_cnt - 1'b1);
          if (wait_cnt == '0) begin
            fetch_lvl <= '0;
            fetch_pos <= '0;
            phase     <= 1'b0;
            state     <= S_TOP;
          end
        end
        S_TOP: begin
          // Read the root back for the top key of the result.
          phase <= !phase;
          if (phase) begin
            root_key <= fetch_key[fetch_lvl];
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.status      <= status;
            rsp.removed_key <= OKW'(removed);
            rsp.top_key     <= (count != '0) ? OKW'(root_key) : '0;
            rsp.held_count  <= OCW'(count);
            rsp.is_empty    <= (count == '0);
            rsp_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The heap never holds more keys than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(HEAP_DEPTH))
    else $error("key count beyond heap depth");

  // An accepted insert with room grows the count by one.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.req_type == bmhq_pkg::REQ_INSERT &&
     count != CW'(HEAP_DEPTH))
    |=> count == CW'($past(count) + 1'b1))
    else $error("insert did not add a key");

  // An accepted remove on a non-empty heap shrinks the count by one.
  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.req_type == bmhq_pkg::REQ_REMOVE &&
     count != '0)
    |=> count == CW'($past(count) - 1'b1))
    else $error("remove did not take a key");

  // An insert always ends at its own level, so only a sift may fall off
  // the bottom of the chain.
  a_insert_ends_in_chain: assert property (@(posedge clk) disable iff (rst)
    tok[NL].valid |-> tok[NL].op == bmhq_pkg::TOK_SIFT)
    else $error("insert token passed the last level");

  // A remove on an empty heap reports an empty heap and no key.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == bmhq_pkg::STATUS_EMPTY)
    |-> (rsp.is_empty && rsp.removed_key == '0))
    else $error("empty remove returned a key");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the binary max-heap priority queue.
// It needs bmhq_pkg and binary_max_heap_queue. A directed table runs first, then
// phases of random requests, each checked against a heap predictor kept here.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bmhq_pkg::*;

  localparam int DEPTH     = HEAP_DEPTH_DEF;
  localparam int TAIL_WAIT = 100;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  binary_max_heap_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // One row of the directed table. When fixed is set, the expected result is
  // typed in the row; otherwise the heap predictor supplies it.
  typedef struct {
    req_t item;
    bit   fixed;
    rsp_t want;
  } row_t;

  // The predictor's own copy of the heap: the array and the number of keys.
  logic [IN_KEY_W-1:0] heap_keys [DEPTH];
  int                  heap_fill;

  // Results the block still owes, oldest first.
  rsp_t awaited_rsp [$];
  row_t directed_rows [$];

  int   errors;
  bit   valid_held;
  int   burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. The slowest correct run is well under two million ns, so a
  // result that never comes ends the run here.
  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  // Applies one request to the predictor's heap and returns the result the
  // block must give for it. Sift up stops at an equal parent; sift down picks
  // the left child on a tie and never swaps with an equal child.
  function automatic rsp_t heap_apply(input req_t item);
    rsp_t                o;
    int                  pos;
    int                  parent;
    int                  lft;
    int                  pick;
    bit                  done;
    logic [IN_KEY_W-1:0] tmp;
    o        = '0;
    o.status = STATUS_OK;
    if (item.req_type == REQ_INSERT) begin
      if (heap_fill >= DEPTH) begin
        o.status = STATUS_FULL;
      end else begin
        heap_keys[heap_fill] = item.key_in;
        pos                  = heap_fill;
        heap_fill++;
        done = 1'b0;
        while (pos > 0 && !done) begin
          parent = (pos - 1) / 2;
          if (heap_keys[parent] < heap_keys[pos]) begin
            tmp               = heap_keys[parent];
            heap_keys[parent] = heap_keys[pos];
            heap_keys[pos]    = tmp;
            pos               = parent;
          end else begin
            done = 1'b1;
          end
        end
      end
    end else begin
      if (heap_fill == 0) begin
        o.status = STATUS_EMPTY;
      end else begin
        o.removed_key = heap_keys[0];
        heap_fill--;
        if (heap_fill > 0) begin
          heap_keys[0] = heap_keys[heap_fill];
          pos          = 0;
          done         = 1'b0;
          while (!done) begin
            lft = 2 * pos + 1;
            if (lft >= heap_fill) begin
              done = 1'b1;
            end else begin
              pick = lft;
              if (lft + 1 < heap_fill && heap_keys[lft] < heap_keys[lft + 1]) begin
                pick = lft + 1;
              end
              if (heap_keys[pos] < heap_keys[pick]) begin
                tmp             = heap_keys[pos];
                heap_keys[pos]  = heap_keys[pick];
                heap_keys[pick] = tmp;
                pos             = pick;
              end else begin
                done = 1'b1;
              end
            end
          end
        end
      end
    end
    o.top_key    = (heap_fill > 0) ? heap_keys[0] : '0;
    o.held_count = heap_fill[OUT_COUNT_W-1:0];
    o.is_empty   = (heap_fill == 0);
    return o;
  endfunction

  function automatic rsp_t make_rsp(input status_t st, input logic [31:0] removed,
                                    input logic [31:0] top, input int count);
    rsp_t o;
    o.status      = st;
    o.removed_key = removed;
    o.top_key     = top;
    o.held_count  = count[OUT_COUNT_W-1:0];
    o.is_empty    = (count == 0);
    return o;
  endfunction

  function automatic req_t make_req(input req_type_t kind, input logic [31:0] key);
    req_t r;
    r.req_type = kind;
    r.key_in   = key;
    return r;
  endfunction

  task automatic add_row(input req_type_t kind, input logic [31:0] key,
                         input bit fixed, input rsp_t want);
    row_t row;
    row.item  = make_req(kind, key);
    row.fixed = fixed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Keys are drawn from a few families: the full range for bit coverage, a
  // tiny range for many equal keys, a narrow band at the top, and the extremes.
  function automatic logic [31:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      return $urandom;
    end else if (sel < 75) begin
      return $urandom_range(0, 7);
    end else if (sel < 90) begin
      return 32'hFFFF_FFF0 | $urandom_range(0, 15);
    end else begin
      case ($urandom_range(0, 3))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        2:       return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
  endfunction

  function automatic req_t random_req(input int insert_pct);
    if ($urandom_range(0, 99) < insert_pct) begin
      return make_req(REQ_INSERT, pick_key());
    end
    return make_req(REQ_REMOVE, $urandom);
  endfunction

  // Offers one item and holds it until the block takes it. The expected result
  // is queued at the accepting edge. The sender works in bursts: when a burst
  // runs out, valid may drop for a random gap before the next one starts.
  task automatic offer(input req_t item, input bit fixed, input rsp_t want);
    rsp_t model;
    int   gap;
    int   sel;
    req <= item;
    if (!valid_held) begin
      req_valid <= 1'b1;
    end
    valid_held = 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    model = heap_apply(item);
    awaited_rsp.push_back(fixed ? want : model);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      sel        = $urandom_range(0, 9);
      if (sel < 4) begin
        gap = 0;
      end else if (sel < 8) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(4, 12);
      end
      if (gap > 0) begin
        req_valid <= 1'b0;
        valid_held = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering and waits until the block has returned every result.
  task automatic wait_drained();
    if (valid_held) begin
      req_valid <= 1'b0;
      valid_held = 1'b0;
    end
    do @(posedge clk); while (awaited_rsp.size() != 0);
  endtask

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  // Sender: reset, the directed table, then three random phases.
  initial begin : sender
    rsp_t none;
    none       = '0;
    errors     = 0;
    heap_fill  = 0;
    valid_held = 1'b0;
    burst_left = 0;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;

    // Directed rows. The opening sequences and the last remove are read off by
    // hand; the rest mix equal keys and bit patterns and are predicted.
    add_row(REQ_REMOVE, 32'hFFFF_FFFF, 1, make_rsp(STATUS_EMPTY, 0, 0, 0));
    add_row(REQ_INSERT, 32'h0000_0000, 1, make_rsp(STATUS_OK, 0, 0, 1));
    add_row(REQ_REMOVE, 32'h0000_0000, 1, make_rsp(STATUS_OK, 0, 0, 0));
    add_row(REQ_INSERT, 32'hFFFF_FFFF, 1, make_rsp(STATUS_OK, 0, 32'hFFFF_FFFF, 1));
    add_row(REQ_INSERT, 32'h0000_0000, 1, make_rsp(STATUS_OK, 0, 32'hFFFF_FFFF, 2));
    add_row(REQ_REMOVE, 32'h5555_5555, 1, make_rsp(STATUS_OK, 32'hFFFF_FFFF, 0, 1));
    add_row(REQ_INSERT, 32'hAAAA_AAAA, 0, none);
    add_row(REQ_INSERT, 32'h5555_5555, 0, none);
    add_row(REQ_INSERT, 32'h5555_5555, 0, none);
    add_row(REQ_INSERT, 32'h5555_5555, 0, none);
    add_row(REQ_INSERT, 32'hAAAA_AAAA, 0, none);
    add_row(REQ_INSERT, 32'h8000_0000, 0, none);
    add_row(REQ_INSERT, 32'h7FFF_FFFF, 0, none);
    add_row(REQ_INSERT, 32'hFFFF_FFFF, 0, none);
    for (int i = 0; i < 9; i++) begin
      add_row(REQ_REMOVE, $urandom, 0, none);
    end
    add_row(REQ_REMOVE, 32'hAAAA_AAAA, 1, make_rsp(STATUS_EMPTY, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
    end
    wait_drained();

    // A balanced mix keeps the heap shallow and hits remove on empty often.
    for (int i = 0; i < 100; i++) begin
      offer(random_req(50), 0, none);
    end
    wait_drained();

    // Mostly inserts until the heap is full, so sifts run over every level.
    // The long receiver hold-off lands in this phase.
    while (heap_fill < DEPTH) begin
      offer(random_req(95), 0, none);
    end

    // Hover at full: rejected inserts mixed with deep removes.
    for (int i = 0; i < 40; i++) begin
      offer(random_req(70), 0, none);
    end
    wait_drained();

    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: checks each accepted result and drives rsp_stall from a mode
  // redrawn at random, plus one long hold-off while the heap fills.
  initial begin : receiver
    rsp_t        want;
    int unsigned results_seen;
    int unsigned holdoff;
    int unsigned cyc;
    int          mode;
    bit          held;
    bit          stall_next;
    results_seen = 0;
    holdoff      = 0;
    cyc          = 0;
    mode         = 0;
    held         = 1'b0;
    rsp_stall    = 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
        results_seen++;
        if (awaited_rsp.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, actual %p", $time, rsp);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.status !== want.status) begin
            report_field("status", want.status, rsp.status);
          end
          if (rsp.removed_key !== want.removed_key) begin
            report_field("removed_key", want.removed_key, rsp.removed_key);
          end
          if (rsp.top_key !== want.top_key) begin
            report_field("top_key", want.top_key, rsp.top_key);
          end
          if (rsp.held_count !== want.held_count) begin
            report_field("held_count", want.held_count, rsp.held_count);
          end
          if (rsp.is_empty !== want.is_empty) begin
            report_field("is_empty", want.is_empty, rsp.is_empty);
          end
        end
      end

      // Start the hold-off once, well into the fill phase, and count it out
      // here so the sender keeps offering and the block backs up.
      if (!held && results_seen == 500) begin
        held    = 1'b1;
        holdoff = 400;
      end

      cyc++;
      if (cyc % 64 == 0) begin
        mode = $urandom_range(0, 3);
      end
      if (holdoff > 0) begin
        holdoff--;
        stall_next = 1'b1;
      end else begin
        case (mode)
          0:       stall_next = 1'b0;
          1:       stall_next = ($urandom_range(0, 3) == 0);
          2:       stall_next = ($urandom_range(0, 3) != 0);
          default: stall_next = (cyc % 5 < 2);
        endcase
      end
      rsp_stall <= stall_next;
    end
  end

endmodule

@@ files.f @@
rtl/core/bmhq_pkg.sv
rtl/core/bmhq_level_cell.sv
rtl/core/binary_max_heap_queue.sv
test/testbench.sv
